FILE: hw/rtl/cmp_pkg.sv
`timescale 1ns / 1ps

package cmp_pkg;

    // Default build values
    localparam int STAGES_DEF     = 16;
    localparam int DATA_WIDTH_DEF = 16;

    // Result field widths
    localparam int MAG_WIDTH   = 16;
    localparam int PHASE_WIDTH = 17;

    // Fixed-point layout of the angle datapath (unit pi/2^31)
    localparam int GUARD_BITS  = 16;
    localparam int ROUND_SHIFT = 16;
    localparam int ANGLE_WIDTH = 34;
    localparam int ATAN_WIDTH  = 31;
    localparam int ATAN_DEPTH  = 32;
    localparam int ATAN_IDX_W  = $clog2(ATAN_DEPTH);

    localparam logic signed [ANGLE_WIDTH-1:0] PI_ANGLE    = ANGLE_WIDTH'(64'sd2147483648);
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_ROUND = ANGLE_WIDTH'(64'sd32768);

    // Output angles for points on the axes (unit pi/32768)
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_ZERO    = PHASE_WIDTH'(0);
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_HALF_PI = PHASE_WIDTH'(16384);
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_PI      = PHASE_WIDTH'(32768);

    // atan(2^-i) in units of pi/2^31, rounded
    function automatic logic [ATAN_WIDTH-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_WIDTH-1:0] val;
        begin
            case (idx)
                5'd0:    val = 31'd536870912;
                5'd1:    val = 31'd316933406;
                5'd2:    val = 31'd167458907;
                5'd3:    val = 31'd85004756;
                5'd4:    val = 31'd42667331;
                5'd5:    val = 31'd21354465;
                5'd6:    val = 31'd10679838;
                5'd7:    val = 31'd5340245;
                5'd8:    val = 31'd2670163;
                5'd9:    val = 31'd1335087;
                5'd10:   val = 31'd667544;
                5'd11:   val = 31'd333772;
                5'd12:   val = 31'd166886;
                5'd13:   val = 31'd83443;
                5'd14:   val = 31'd41722;
                5'd15:   val = 31'd20861;
                5'd16:   val = 31'd10430;
                5'd17:   val = 31'd5215;
                5'd18:   val = 31'd2608;
                5'd19:   val = 31'd1304;
                5'd20:   val = 31'd652;
                5'd21:   val = 31'd326;
                5'd22:   val = 31'd163;
                5'd23:   val = 31'd81;
                5'd24:   val = 31'd41;
                5'd25:   val = 31'd20;
                5'd26:   val = 31'd10;
                5'd27:   val = 31'd5;
                5'd28:   val = 31'd3;
                5'd29:   val = 31'd1;
                5'd30:   val = 31'd1;
                default: val = 31'd0;
            endcase
            return val;
        end
    endfunction

endpackage

FILE: hw/rtl/cmp_in_if.sv
`timescale 1ns / 1ps

interface cmp_in_if
    import cmp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] real_part;
    logic signed [DATA_WIDTH-1:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

FILE: hw/rtl/cmp_out_if.sv
`timescale 1ns / 1ps

interface cmp_out_if
    import cmp_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic        [MAG_WIDTH-1:0]   magnitude;
    logic signed [PHASE_WIDTH-1:0] phase_angle;

    modport source (output valid, output magnitude, output phase_angle, input ready);
    modport sink   (input valid, input magnitude, input phase_angle, output ready);
endinterface

FILE: hw/rtl/cmp_cordic.sv
`timescale 1ns / 1ps

module cmp_cordic
    import cmp_pkg::*;
#(
    parameter int STAGES     = STAGES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PAD        = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [DATA_WIDTH-1:0]  real_part,
    input  logic signed [DATA_WIDTH-1:0]  imag_part,
    output logic signed [PHASE_WIDTH-1:0] phase_angle
);
    localparam int XW = DATA_WIDTH + GUARD_BITS + 3;

    logic signed [XW-1:0]          x_reg    [STAGES+1];
    logic signed [XW-1:0]          y_reg    [STAGES+1];
    logic signed [ANGLE_WIDTH-1:0] z_reg    [STAGES+1];
    logic                          axis_reg [STAGES+1];
    logic signed [PHASE_WIDTH-1:0] axis_ang_reg [STAGES+1];

    logic signed [DATA_WIDTH:0]    re_w;
    logic signed [DATA_WIDTH:0]    im_w;
    logic                          left_half;
    logic signed [XW-1:0]          x_next;
    logic signed [XW-1:0]          y_next;
    logic signed [ANGLE_WIDTH-1:0] z_next;
    logic                          axis_next;
    logic signed [PHASE_WIDTH-1:0] axis_ang_next;

    // Fold the left half-plane onto the right, seed the angle with +-pi
    always_comb
    begin
        re_w      = (DATA_WIDTH+1)'(real_part);
        im_w      = (DATA_WIDTH+1)'(imag_part);
        left_half = real_part[DATA_WIDTH-1];
        if (left_half)
        begin
            x_next = XW'(-re_w) <<< GUARD_BITS;
            y_next = XW'(-im_w) <<< GUARD_BITS;
            z_next = imag_part[DATA_WIDTH-1] ? -PI_ANGLE : PI_ANGLE;
        end
        else
        begin
            x_next = XW'(re_w) <<< GUARD_BITS;
            y_next = XW'(im_w) <<< GUARD_BITS;
            z_next = '0;
        end
    end

    // Points on an axis bypass the rotation; the origin reads as -pi/2
    always_comb
    begin
        axis_next = (real_part == '0) || (imag_part == '0);
        if (real_part == '0)
        begin
            axis_ang_next = (imag_part > 0) ? PHASE_HALF_PI : -PHASE_HALF_PI;
        end
        else
        begin
            axis_ang_next = left_half ? PHASE_PI : PHASE_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]        <= x_next;
            y_reg[0]        <= y_next;
            z_reg[0]        <= z_next;
            axis_reg[0]     <= axis_next;
            axis_ang_reg[0] <= axis_ang_next;
        end
    end

    // One micro-rotation per stage, driving y toward zero
    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        localparam logic signed [ANGLE_WIDTH-1:0] ATAN_I =
            ANGLE_WIDTH'(atan_lut(ATAN_IDX_W'(i)));

        logic signed [XW-1:0]          xs;
        logic signed [XW-1:0]          ys;
        logic signed [XW-1:0]          x_rot_next;
        logic signed [XW-1:0]          y_rot_next;
        logic signed [ANGLE_WIDTH-1:0] z_rot_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (!y_reg[i][XW-1])
            begin
                x_rot_next = x_reg[i] + ys;
                y_rot_next = y_reg[i] - xs;
                z_rot_next = z_reg[i] + ATAN_I;
            end
            else
            begin
                x_rot_next = x_reg[i] - ys;
                y_rot_next = y_reg[i] + xs;
                z_rot_next = z_reg[i] - ATAN_I;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]        <= x_rot_next;
                y_reg[i+1]        <= y_rot_next;
                z_reg[i+1]        <= z_rot_next;
                axis_reg[i+1]     <= axis_reg[i];
                axis_ang_reg[i+1] <= axis_ang_reg[i];
            end
        end
    end

    // Round to units of pi/32768, half rounds up
    logic signed [ANGLE_WIDTH-1:0] z_round;
    logic signed [PHASE_WIDTH-1:0] phase_next;
    logic signed [PHASE_WIDTH-1:0] phase_reg;

    always_comb
    begin
        z_round = z_reg[STAGES] + ANGLE_ROUND;
        if (axis_reg[STAGES])
        begin
            phase_next = axis_ang_reg[STAGES];
        end
        else
        begin
            phase_next = $signed(z_round[ROUND_SHIFT +: PHASE_WIDTH]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_reg <= phase_next;
        end
    end

    // Delay to line up with the magnitude path
    if (PAD > 0)
    begin : g_pad
        logic signed [PHASE_WIDTH-1:0] pad_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= phase_reg;
                for (int k = 1; k < PAD; k++)
                begin
                    pad_reg[k] <= pad_reg[k-1];
                end
            end
        end

        assign phase_angle = pad_reg[PAD-1];
    end
    else
    begin : g_nopad
        assign phase_angle = phase_reg;
    end

endmodule

FILE: hw/rtl/cmp_isqrt.sv
`timescale 1ns / 1ps

module cmp_isqrt
    import cmp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PAD        = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] real_part,
    input  logic signed [DATA_WIDTH-1:0] imag_part,
    output logic        [MAG_WIDTH-1:0]  magnitude
);
    localparam int DW = DATA_WIDTH;
    localparam int NW = 2 * DATA_WIDTH;
    localparam int RW = DATA_WIDTH + 2;

    // Absolute values
    logic signed [DW:0] re_w;
    logic signed [DW:0] im_w;
    logic [DW-1:0]      are_next;
    logic [DW-1:0]      aim_next;
    logic [DW-1:0]      are_reg;
    logic [DW-1:0]      aim_reg;

    always_comb
    begin
        re_w     = (DW+1)'(real_part);
        im_w     = (DW+1)'(imag_part);
        are_next = real_part[DW-1] ? DW'(-re_w) : DW'(re_w);
        aim_next = imag_part[DW-1] ? DW'(-im_w) : DW'(im_w);
    end

    // Square each part, then sum
    logic [NW-1:0] sq_re_reg;
    logic [NW-1:0] sq_im_reg;
    logic [NW-1:0] n_reg    [DW+1];
    logic [RW-1:0] rem_reg  [DW+1];
    logic [DW-1:0] root_reg [DW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            are_reg     <= are_next;
            aim_reg     <= aim_next;
            sq_re_reg   <= are_reg * are_reg;
            sq_im_reg   <= aim_reg * aim_reg;
            n_reg[0]    <= sq_re_reg + sq_im_reg;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // Restoring square root, one result bit per stage
    for (genvar j = 0; j < DW; j++)
    begin : g_bit
        logic [RW+1:0] rem_cat;
        logic [RW+1:0] trial;
        logic [RW-1:0] rem_next;
        logic [DW-1:0] root_next;

        always_comb
        begin
            rem_cat = {rem_reg[j], n_reg[j][NW-1 -: 2]};
            trial   = {2'b00, root_reg[j], 2'b01};
            if (rem_cat >= trial)
            begin
                rem_next  = RW'(rem_cat - trial);
                root_next = {root_reg[j][DW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RW'(rem_cat);
                root_next = {root_reg[j][DW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[j+1]    <= n_reg[j] << 2;
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the root
    logic [DW:0]          mag_full;
    logic [MAG_WIDTH-1:0] mag_next;
    logic [MAG_WIDTH-1:0] mag_reg;

    always_comb
    begin
        mag_full = (DW+1)'(root_reg[DW])
                 + (DW+1)'(rem_reg[DW] > RW'(root_reg[DW]));
        mag_next = MAG_WIDTH'(mag_full);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
        end
    end

    // Delay to line up with the angle path
    if (PAD > 0)
    begin : g_pad
        logic [MAG_WIDTH-1:0] pad_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= mag_reg;
                for (int k = 1; k < PAD; k++)
                begin
                    pad_reg[k] <= pad_reg[k-1];
                end
            end
        end

        assign magnitude = pad_reg[PAD-1];
    end
    else
    begin : g_nopad
        assign magnitude = mag_reg;
    end

endmodule

FILE: hw/rtl/complex_magnitude_phase.sv
// The longer of the CORDIC and the bit-per-stage square root sets when a result appears;
// the shorter path is delayed with pad registers to line up with it.
// Throughput: one beat per cycle; a stall on the output freezes the whole pipeline.
// Reset (rst_n, asynchronous, active low) clears the valid bits only; no other state.
`timescale 1ns / 1ps

module complex_magnitude_phase
    import cmp_pkg::*;
#(
    parameter int STAGES     = STAGES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cmp_in_if.sink    sample_in,
    cmp_out_if.source result_out
);
    localparam int LAT_PHASE = STAGES + 2;
    localparam int LAT_MAG   = DATA_WIDTH + 4;
    localparam int LAT       = (LAT_PHASE > LAT_MAG) ? LAT_PHASE : LAT_MAG;

    logic           en;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    // Advance whenever the output slot is empty or being taken
    assign en              = !valid_reg[LAT-1] || result_out.ready;
    assign sample_in.ready = en;
    assign result_out.valid = valid_reg[LAT-1];

    always_comb
    begin
        valid_next = {valid_reg[LAT-2:0], sample_in.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    cmp_cordic #(
        .STAGES     (STAGES),
        .DATA_WIDTH (DATA_WIDTH),
        .PAD        (LAT - LAT_PHASE)
    ) u_cordic (
        .clk         (clk),
        .en          (en),
        .real_part   (sample_in.real_part),
        .imag_part   (sample_in.imag_part),
        .phase_angle (result_out.phase_angle)
    );

    cmp_isqrt #(
        .DATA_WIDTH (DATA_WIDTH),
        .PAD        (LAT - LAT_MAG)
    ) u_isqrt (
        .clk       (clk),
        .en        (en),
        .real_part (sample_in.real_part),
        .imag_part (sample_in.imag_part),
        .magnitude (result_out.magnitude)
    );

endmodule
